// File: rtl/tgad_pkg.sv
// shared types, constants and helpers of the run-length pixel decoder
package tgad_pkg;

   localparam int COORD_BITS = 16;
   localparam logic [15:0] COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);

   localparam logic [7:0] COUNT_MASK  = 8'h7F;
   localparam logic [7:0] REPEAT_FLAG = 8'h80;

   // dividend of the position update is column plus run length
   localparam int DIV_BITS     = 17;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_RAW,
      PH_REPEAT
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_TOT,
      ST_MUL_IDX,
      ST_CHECK,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_BYTES_PER_PIXEL,
      CSR_ALPHA_BITS,
      CSR_RLE_MODE,
      CSR_GRAY_EXPAND,
      CSR_FLIP_X,
      CSR_TOP_ORIGIN
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // source bytes that make up one pixel
   function automatic logic [2:0] pixel_bytes(input logic gray, input logic [2:0] bpp);
      logic [2:0] res;
      if (gray || bpp == 3'd0) begin
         res = 3'd1;
      end else if (bpp > 3'd4) begin
         res = 3'd4;
      end else begin
         res = bpp;
      end
      return res;
   endfunction

   // zero size acts as one
   function automatic logic [15:0] eff_dim(input logic [15:0] dim);
      return (dim == 16'd0) ? 16'd1 : dim;
   endfunction

endpackage

// File: rtl/tga_rle_pixel_decoder.sv
// top level of the run-length pixel stream decoder
// a header byte passes accept, two multiplies and check; a byte that does not end a
//   pixel is only accepted; one that does adds the divider, unless it overflows, and emit
// throughput: one request at a time; the 17 step divider that wraps column into row
//   sets the cost of every pixel or repeat run
// reset: synchronous, active high; registers to defaults, decoder waits for a header
module tga_rle_pixel_decoder (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_value,
   output logic [15:0] rsp_dest_x,
   output logic [15:0] rsp_dest_y,
   output logic [7:0]  rsp_run_length,
   output logic        rsp_end_of_image,
   output logic        rsp_overflow_error
);

   // configuration registers
   logic [15:0] width_ff;
   logic [15:0] height_ff;
   logic [2:0]  bpp_ff;
   logic [3:0]  alpha_ff;
   logic        rle_ff;
   logic        gray_ff;
   logic        flip_x_ff;
   logic        top_origin_ff;

   // sequencer
   tgad_pkg::state_type state_ff, state_in;

   // decoder state
   tgad_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        repeat_ff, repeat_in;
   logic [1:0]  byte_index_ff, byte_index_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] column_ff, column_in;
   logic [15:0] row_ff, row_in;
   logic        halted_ff, halted_in;

   // per request working registers
   logic [7:0]  hdr_ff, hdr_in;
   logic        is_header_ff, is_header_in;
   logic [7:0]  n_ff, n_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] mul_ff, mul_in;
   logic [31:0] total_ff, total_in;
   logic [15:0] x_ff, x_in;
   logic [15:0] y_ff, y_in;
   logic        ovf_ff, ovf_in;
   logic        eoi_ff, eoi_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [15:0] rsp_x_ff, rsp_x_in;
   logic [15:0] rsp_y_ff, rsp_y_in;
   logic [7:0]  rsp_len_ff, rsp_len_in;
   logic        rsp_eoi_ff, rsp_eoi_in;
   logic        rsp_err_ff, rsp_err_in;

   // helpers
   logic [15:0] w_eff;
   logic [15:0] h_eff;
   logic [2:0]  pbytes;
   logic [31:0] acc_new;
   logic [31:0] fmt_value;
   logic [32:0] end_sum;
   logic        rsp_free;

   // divider link
   logic                                div_start;
   logic [tgad_pkg::DIV_BITS-1:0]       div_dividend;
   tgad_pkg::div_status_type            div_stat;
   logic [tgad_pkg::DIV_BITS-1:0]       div_quot;
   logic [15:0]                         div_rem;

   assign w_eff    = tgad_pkg::eff_dim(width_ff);
   assign h_eff    = tgad_pkg::eff_dim(height_ff);
   assign pbytes   = tgad_pkg::pixel_bytes(gray_ff, bpp_ff);
   // little-endian assembly of the pixel word
   assign acc_new  = acc_ff | ({24'h000000, req_data_byte} << {byte_index_ff, 3'b000});
   // index of the run's last pixel plus one, against the pixel count
   assign end_sum  = {1'b0, mul_ff} + {17'h00000, column_ff} + {25'h0000000, n_ff};
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign div_dividend = {1'b0, column_ff} + {9'h000, n_ff};

   tgad_pixfmt u_pixfmt (
      .acc             (acc_new),
      .gray_expand     (gray_ff),
      .bytes_per_pixel (bpp_ff),
      .alpha_bits      (alpha_ff),
      .pixel_value     (fmt_value)
   );

   // wraps column plus run length into row and column
   tgad_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (w_eff),
      .status    (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 16'd1;
         height_ff     <= 16'd1;
         bpp_ff        <= 3'd4;
         alpha_ff      <= 4'd0;
         rle_ff        <= 1'b0;
         gray_ff       <= 1'b0;
         flip_x_ff     <= 1'b0;
         top_origin_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (tgad_pkg::csr_index_type'(csr_index))
            tgad_pkg::CSR_IMAGE_WIDTH:     width_ff      <= csr_data;
            tgad_pkg::CSR_IMAGE_HEIGHT:    height_ff     <= csr_data;
            tgad_pkg::CSR_BYTES_PER_PIXEL: bpp_ff        <= csr_data[2:0];
            tgad_pkg::CSR_ALPHA_BITS:      alpha_ff      <= csr_data[3:0];
            tgad_pkg::CSR_RLE_MODE:        rle_ff        <= csr_data[0];
            tgad_pkg::CSR_GRAY_EXPAND:     gray_ff       <= csr_data[0];
            tgad_pkg::CSR_FLIP_X:          flip_x_ff     <= csr_data[0];
            tgad_pkg::CSR_TOP_ORIGIN:      top_origin_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // sequencer: next state and all register updates but the configuration
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      packet_left_in = packet_left_ff;
      repeat_in      = repeat_ff;
      byte_index_in  = byte_index_ff;
      acc_in         = acc_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      halted_in      = halted_ff;
      hdr_in         = hdr_ff;
      is_header_in   = is_header_ff;
      n_in           = n_ff;
      value_in       = value_ff;
      mul_in         = mul_ff;
      total_in       = total_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      ovf_in         = ovf_ff;
      eoi_in         = eoi_ff;
      div_start      = 1'b0;
      // a waiting response leaves once taken
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_value_in   = rsp_value_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_eoi_in     = rsp_eoi_ff;
      rsp_err_in     = rsp_err_ff;

      unique case (state_ff)
         tgad_pkg::ST_IDLE: begin
            // a halted decoder drops every request
            if (req_valid && !halted_ff) begin
               if (rle_ff && phase_ff == tgad_pkg::PH_HEADER) begin
                  hdr_in       = req_data_byte;
                  n_in         = (req_data_byte & tgad_pkg::COUNT_MASK) + 8'd1;
                  is_header_in = 1'b1;
                  state_in     = tgad_pkg::ST_MUL_TOT;
               end else if ({1'b0, byte_index_ff} + 3'd1 < pbytes) begin
                  acc_in        = acc_new;
                  byte_index_in = byte_index_ff + 2'd1;
               end else begin
                  value_in      = fmt_value;
                  acc_in        = '0;
                  byte_index_in = '0;
                  is_header_in  = 1'b0;
                  state_in      = tgad_pkg::ST_MUL_TOT;
                  if (!rle_ff) begin
                     n_in = 8'd1;
                  end else if (phase_ff == tgad_pkg::PH_REPEAT) begin
                     n_in           = (packet_left_ff != 8'd0) ? packet_left_ff : 8'd1;
                     packet_left_in = 8'd0;
                     phase_in       = tgad_pkg::PH_HEADER;
                  end else begin
                     n_in = 8'd1;
                     if (packet_left_ff <= 8'd1) begin
                        packet_left_in = 8'd0;
                        phase_in       = tgad_pkg::PH_HEADER;
                     end else begin
                        packet_left_in = packet_left_ff - 8'd1;
                     end
                  end
               end
            end
         end
         tgad_pkg::ST_MUL_TOT: begin
            mul_in   = {16'h0000, w_eff} * {16'h0000, h_eff};
            state_in = tgad_pkg::ST_MUL_IDX;
         end
         tgad_pkg::ST_MUL_IDX: begin
            total_in = mul_ff;
            mul_in   = {16'h0000, row_ff} * {16'h0000, w_eff};
            state_in = tgad_pkg::ST_CHECK;
         end
         tgad_pkg::ST_CHECK: begin
            ovf_in = end_sum > {1'b0, total_ff};
            eoi_in = end_sum == {1'b0, total_ff};
            x_in   = (flip_x_ff ? (w_eff - 16'd1 - column_ff) : column_ff)
                     & tgad_pkg::COORD_MASK;
            y_in   = (top_origin_ff ? row_ff : (h_eff - 16'd1 - row_ff))
                     & tgad_pkg::COORD_MASK;
            if (end_sum > {1'b0, total_ff}) begin
               state_in = tgad_pkg::ST_EMIT;
            end else if (is_header_ff) begin
               // packet opens, no response
               packet_left_in = n_ff;
               repeat_in      = (hdr_ff & tgad_pkg::REPEAT_FLAG) != 8'h00;
               phase_in       = ((hdr_ff & tgad_pkg::REPEAT_FLAG) != 8'h00) ?
                                tgad_pkg::PH_REPEAT : tgad_pkg::PH_RAW;
               byte_index_in  = '0;
               acc_in         = '0;
               state_in       = tgad_pkg::ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = tgad_pkg::ST_DIV;
            end
         end
         tgad_pkg::ST_DIV: begin
            if (div_stat.done) begin
               row_in    = row_ff + div_quot[15:0];
               column_in = div_rem;
               state_in  = tgad_pkg::ST_EMIT;
            end
         end
         tgad_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = ovf_ff;
               rsp_value_in = ovf_ff ? 32'h0 : value_ff;
               rsp_x_in     = ovf_ff ? 16'h0 : x_ff;
               rsp_y_in     = ovf_ff ? 16'h0 : y_ff;
               rsp_len_in   = ovf_ff ? 8'h0 : n_ff;
               rsp_eoi_in   = !ovf_ff && eoi_ff;
               halted_in    = ovf_ff || eoi_ff;
               state_in     = tgad_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tgad_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tgad_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // decoder state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= tgad_pkg::PH_HEADER;
         packet_left_ff <= 8'd0;
         repeat_ff      <= 1'b0;
         byte_index_ff  <= 2'd0;
         acc_ff         <= 32'h0;
         column_ff      <= 16'd0;
         row_ff         <= 16'd0;
         halted_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         packet_left_ff <= packet_left_in;
         repeat_ff      <= repeat_in;
         byte_index_ff  <= byte_index_in;
         acc_ff         <= acc_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
         halted_ff      <= halted_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      hdr_ff       <= hdr_in;
      is_header_ff <= is_header_in;
      n_ff         <= n_in;
      value_ff     <= value_in;
      mul_ff       <= mul_in;
      total_ff     <= total_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      ovf_ff       <= ovf_in;
      eoi_ff       <= eoi_in;
      rsp_value_ff <= rsp_value_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_eoi_ff   <= rsp_eoi_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // one request at a time; a finished response may still wait downstream
   assign req_stall          = state_ff != tgad_pkg::ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_value    = rsp_value_ff;
   assign rsp_dest_x         = rsp_x_ff;
   assign rsp_dest_y         = rsp_y_ff;
   assign rsp_run_length     = rsp_len_ff;
   assign rsp_end_of_image   = rsp_eoi_ff;
   assign rsp_overflow_error = rsp_err_ff;

   // an overflow record carries no run and never closes the image
   a_ovf_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_error |-> rsp_run_length == 8'd0 && !rsp_end_of_image)
      else $error("overflow record with run or end flag");

   // a good record always covers at least one pixel
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflow_error |-> rsp_run_length != 8'd0)
      else $error("empty run in good record");

   // once halted the sequencer stays idle
   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> state_ff == tgad_pkg::ST_IDLE)
      else $error("sequencer active while halted");

   // waiting on the divider only while it works
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == tgad_pkg::ST_DIV |-> div_stat.busy)
      else $error("divider idle during position update");

endmodule

// File: rtl/tgad_div.sv
// iterative restoring divider, one quotient bit per cycle
module tgad_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tgad_pkg::DIV_BITS-1:0]    dividend,
   input  logic [15:0]                      divisor,
   output tgad_pkg::div_status_type         status,
   output logic [tgad_pkg::DIV_BITS-1:0]    quotient,
   output logic [15:0]                      remainder
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [tgad_pkg::DIV_CNT_BITS-1:0]   count_ff, count_in;
   logic [15:0]                         rem_ff, rem_in;
   logic [tgad_pkg::DIV_BITS-1:0]       quo_ff, quo_in;
   logic [16:0]                         trial;
   logic                                fits;

   // shared subtract and compare
   assign trial = {rem_ff, quo_ff[tgad_pkg::DIV_BITS-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
         quo_in   = {quo_ff[tgad_pkg::DIV_BITS-2:0], fits};
         count_in = count_ff + tgad_pkg::DIV_CNT_BITS'(1);
         if (count_ff == tgad_pkg::DIV_CNT_BITS'(tgad_pkg::DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff | done_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// File: rtl/tgad_pixfmt.sv
// pixel word formation: byte mask, alpha rotation, gray replication
module tgad_pixfmt (
   input  logic [31:0] acc,
   input  logic        gray_expand,
   input  logic [2:0]  bytes_per_pixel,
   input  logic [3:0]  alpha_bits,
   output logic [31:0] pixel_value
);

   logic [2:0]  pbytes;
   logic [5:0]  pbits;
   logic [31:0] mask;
   logic [31:0] masked;
   logic [31:0] rotated;
   logic        no_rot;

   always_comb begin
      pbytes  = tgad_pkg::pixel_bytes(gray_expand, bytes_per_pixel);
      pbits   = {pbytes, 3'b000};
      // a full word gives a zero shift result, minus one is all ones
      mask    = (32'd1 << pbits) - 32'd1;
      masked  = acc & mask;
      no_rot  = (alpha_bits == 4'd0) || ({2'b00, alpha_bits} >= pbits);
      rotated = ((masked << alpha_bits) | (masked >> (pbits - {2'b00, alpha_bits}))) & mask;
      if (gray_expand) begin
         pixel_value = {8'h00, acc[7:0], acc[7:0], acc[7:0]};
      end else if (no_rot) begin
         pixel_value = masked;
      end else begin
         pixel_value = rotated;
      end
   end

endmodule

// File: verif/tb_top.sv
// self-checking testbench of the run-length pixel stream decoder
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 40;
   localparam int HOLD_TICKS   = 400;
   localparam int PHASE_COUNT  = 12;
   localparam int PHASE_BYTES  = 115;

   typedef struct {
      logic [31:0] pixel_value;
      logic [15:0] dest_x;
      logic [15:0] dest_y;
      logic [7:0]  run_length;
      logic        end_of_image;
      logic        overflow_error;
   } run_rec_type;

   typedef enum {FEED_NORMAL, FEED_FINISH, FEED_OVERRUN} feed_mode_type;
   typedef enum {END_COMPLETE, END_OVERRUN, END_OUTSIDE} ending_type;

   // predicts the run records of the byte stream and checks them in order
   class run_record_board_type;
      logic [15:0] image_width, image_height;
      logic [2:0]  bytes_per_pixel;
      logic [3:0]  alpha_bits;
      logic        rle_mode, gray_expand, flip_x, top_origin;
      tgad_pkg::phase_type phase;
      logic [7:0]  packet_left;
      logic        packet_is_repeat;
      logic [1:0]  byte_index;
      logic [31:0] pixel_acc;
      logic [15:0] column, row;
      bit          halted;
      run_rec_type expected_runs[$];
      int          failures;
      int          runs_checked;

      function new();
         image_width = 16'd1;
         image_height = 16'd1;
         bytes_per_pixel = 3'd4;
         alpha_bits = 4'd0;
         rle_mode = 1'b0;
         gray_expand = 1'b0;
         flip_x = 1'b0;
         top_origin = 1'b0;
         phase = tgad_pkg::PH_HEADER;
         packet_left = 8'd0;
         packet_is_repeat = 1'b0;
         byte_index = 2'd0;
         pixel_acc = 32'd0;
         column = 16'd0;
         row = 16'd0;
         halted = 1'b0;
         failures = 0;
         runs_checked = 0;
      endfunction

      function void write_reg(tgad_pkg::csr_index_type idx, logic [15:0] data);
         case (idx)
            tgad_pkg::CSR_IMAGE_WIDTH:     image_width = data;
            tgad_pkg::CSR_IMAGE_HEIGHT:    image_height = data;
            tgad_pkg::CSR_BYTES_PER_PIXEL: bytes_per_pixel = data[2:0];
            tgad_pkg::CSR_ALPHA_BITS:      alpha_bits = data[3:0];
            tgad_pkg::CSR_RLE_MODE:        rle_mode = data[0];
            tgad_pkg::CSR_GRAY_EXPAND:     gray_expand = data[0];
            tgad_pkg::CSR_FLIP_X:          flip_x = data[0];
            tgad_pkg::CSR_TOP_ORIGIN:      top_origin = data[0];
            default: ;
         endcase
      endfunction

      function longint unsigned pixels_left_with(logic [15:0] w, logic [15:0] h);
         longint unsigned we, he, total, idx;
         we = (w == 16'd0) ? 1 : w;
         he = (h == 16'd0) ? 1 : h;
         total = we * he;
         idx = longint'(row) * we + column;
         return (idx < total) ? total - idx : 0;
      endfunction

      function longint unsigned pixels_remaining();
         return pixels_left_with(image_width, image_height);
      endfunction

      function int bytes_in_pixel();
         if (gray_expand || bytes_per_pixel == 3'd0) return 1;
         if (bytes_per_pixel > 3'd4) return 4;
         return int'(bytes_per_pixel);
      endfunction

      // alpha rotation within the pixel's own width, or gray replication
      function logic [31:0] shape_pixel(logic [31:0] acc);
         logic [63:0] v, mask;
         int pbits;
         if (gray_expand) return {8'd0, acc[7:0], acc[7:0], acc[7:0]};
         pbits = bytes_in_pixel() * 8;
         mask = (64'd1 << pbits) - 64'd1;
         v = {32'd0, acc} & mask;
         if (alpha_bits == 4'd0 || int'(alpha_bits) >= pbits) return v[31:0];
         v = ((v << alpha_bits) | (v >> (pbits - int'(alpha_bits)))) & mask;
         return v[31:0];
      endfunction

      function void push_overflow();
         expected_runs.push_back('{32'd0, 16'd0, 16'd0, 8'd0, 1'b0, 1'b1});
         halted = 1'b1;
      endfunction

      function void note_byte(logic [7:0] b);
         logic [31:0] n, value, we, he, sum, xv, yv;
         run_rec_type rec;
         if (halted) return;
         if (rle_mode && phase == tgad_pkg::PH_HEADER) begin
            n = {24'd0, b & tgad_pkg::COUNT_MASK} + 32'd1;
            if (n > pixels_remaining()) begin
               push_overflow();
               return;
            end
            packet_left = n[7:0];
            packet_is_repeat = (b & tgad_pkg::REPEAT_FLAG) != 8'd0;
            phase = packet_is_repeat ? tgad_pkg::PH_REPEAT : tgad_pkg::PH_RAW;
            byte_index = 2'd0;
            pixel_acc = 32'd0;
            return;
         end
         pixel_acc = pixel_acc | ({24'd0, b} << (8 * int'(byte_index)));
         if (int'(byte_index) + 1 < bytes_in_pixel()) begin
            byte_index = byte_index + 2'd1;
            return;
         end
         value = shape_pixel(pixel_acc);
         byte_index = 2'd0;
         pixel_acc = 32'd0;
         if (!rle_mode) begin
            n = 32'd1;
         end else if (phase == tgad_pkg::PH_REPEAT) begin
            n = (packet_left != 8'd0) ? {24'd0, packet_left} : 32'd1;
            packet_left = 8'd0;
            phase = tgad_pkg::PH_HEADER;
         end else begin
            n = 32'd1;
            packet_left = (packet_left != 8'd0) ? packet_left - 8'd1 : 8'd0;
            if (packet_left == 8'd0) phase = tgad_pkg::PH_HEADER;
         end
         if (n > pixels_remaining()) begin
            push_overflow();
            return;
         end
         we = (image_width == 16'd0) ? 32'd1 : {16'd0, image_width};
         he = (image_height == 16'd0) ? 32'd1 : {16'd0, image_height};
         xv = flip_x ? we - 32'd1 - {16'd0, column} : {16'd0, column};
         yv = top_origin ? {16'd0, row} : he - 32'd1 - {16'd0, row};
         sum = {16'd0, column} + n;
         row = 16'({16'd0, row} + sum / we);
         column = 16'(sum % we);
         rec.pixel_value = value;
         rec.dest_x = xv[15:0] & tgad_pkg::COORD_MASK;
         rec.dest_y = yv[15:0] & tgad_pkg::COORD_MASK;
         rec.run_length = n[7:0];
         rec.end_of_image = (pixels_remaining() == 0);
         rec.overflow_error = 1'b0;
         if (rec.end_of_image) halted = 1'b1;
         expected_runs.push_back(rec);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            failures++;
            if (failures <= 100)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_run(run_rec_type got);
         run_rec_type want;
         if (expected_runs.size() == 0) begin
            failures++;
            if (failures <= 100)
               $display("%0t: run record with none expected, actual value %0h x %0h y %0h len %0d",
                        $time, got.pixel_value, got.dest_x, got.dest_y, got.run_length);
            return;
         end
         want = expected_runs.pop_front();
         runs_checked++;
         compare_field("pixel_value", want.pixel_value, got.pixel_value);
         compare_field("dest_x", 32'(want.dest_x), 32'(got.dest_x));
         compare_field("dest_y", 32'(want.dest_y), 32'(got.dest_y));
         compare_field("run_length", 32'(want.run_length), 32'(got.run_length));
         compare_field("end_of_image", 32'(want.end_of_image), 32'(got.end_of_image));
         compare_field("overflow_error", 32'(want.overflow_error), 32'(got.overflow_error));
      endfunction

      function int pending();
         return expected_runs.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [15:0] csr_data = 16'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pixel_value;
   logic [15:0] rsp_dest_x;
   logic [15:0] rsp_dest_y;
   logic [7:0]  rsp_run_length;
   logic        rsp_end_of_image;
   logic        rsp_overflow_error;

   run_record_board_type board = new();
   bit          steady = 1'b0;     // no random idling on either side while set
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          cycle_count = 0;
   run_rec_type seen_run;

   tga_rle_pixel_decoder DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_dest_x         (rsp_dest_x),
      .rsp_dest_y         (rsp_dest_y),
      .rsp_run_length     (rsp_run_length),
      .rsp_end_of_image   (rsp_end_of_image),
      .rsp_overflow_error (rsp_overflow_error)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   // response side: random stalls, plus one long hold-off once traffic is flowing
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && board.runs_checked >= 250) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_TICKS;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 14);
      end
   end

   // every accepted record is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_run.pixel_value = rsp_pixel_value;
         seen_run.dest_x = rsp_dest_x;
         seen_run.dest_y = rsp_dest_y;
         seen_run.run_length = rsp_run_length;
         seen_run.end_of_image = rsp_end_of_image;
         seen_run.overflow_error = rsp_overflow_error;
         board.check_run(seen_run);
      end
   end

   // one request; called just after a rising edge, returns at the accepting edge
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      board.note_byte(b);
   endtask

   task automatic send_bytes(input logic [7:0] list[$]);
      foreach (list[i]) send_byte(list[i]);
   endtask

   // drop valid, let every predicted record arrive, then cover a header still in work
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // unused upper bits of narrow registers carry junk
   task automatic write_csr(input tgad_pkg::csr_index_type idx, input logic [15:0] value,
                            input int bits);
      logic [15:0] junk;
      junk = 16'($urandom);
      if (bits < 16) value = value | (junk << bits);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      board.write_reg(idx, value);
   endtask

   task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic [2:0] bpp,
                            input logic [3:0] alpha, input logic rle, input logic gray,
                            input logic flip, input logic top);
      write_csr(tgad_pkg::CSR_IMAGE_WIDTH, w, 16);
      write_csr(tgad_pkg::CSR_IMAGE_HEIGHT, h, 16);
      write_csr(tgad_pkg::CSR_BYTES_PER_PIXEL, {13'd0, bpp}, 3);
      write_csr(tgad_pkg::CSR_ALPHA_BITS, {12'd0, alpha}, 4);
      write_csr(tgad_pkg::CSR_RLE_MODE, {15'd0, rle}, 1);
      write_csr(tgad_pkg::CSR_GRAY_EXPAND, {15'd0, gray}, 1);
      write_csr(tgad_pkg::CSR_FLIP_X, {15'd0, flip}, 1);
      write_csr(tgad_pkg::CSR_TOP_ORIGIN, {15'd0, top}, 1);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // next byte of a well-formed stream; packet counts are kept inside the image
   // unless an overrun is wanted
   function automatic logic [7:0] next_stream_byte(input feed_mode_type mode);
      longint unsigned left, limit;
      int count, pick;
      logic repeat_bit;
      if (board.rle_mode && board.phase == tgad_pkg::PH_HEADER) begin
         left = board.pixels_remaining();
         limit = (mode == FEED_NORMAL && left > 0) ? left - 1 : left;
         repeat_bit = 1'($urandom_range(1));
         pick = $urandom_range(19);
         if (mode == FEED_OVERRUN) count = 128;
         else if (pick < 3 && (repeat_bit || pick == 0)) count = 128;
         else if (pick < 6) count = 1;
         else if (pick < 16) count = repeat_bit ? $urandom_range(1, 128) : $urandom_range(1, 8);
         else count = $urandom_range(1, 128);
         if (mode != FEED_OVERRUN && count > limit) count = (limit == 0) ? 1 : int'(limit);
         return {repeat_bit, 7'(count - 1)};
      end
      pick = $urandom_range(7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   function automatic bit at_packet_edge();
      return board.byte_index == 2'd0 &&
             (!board.rle_mode || board.phase == tgad_pkg::PH_HEADER);
   endfunction

   task automatic run_phase(input int target, input bit pause_midway);
      int sent;
      sent = 0;
      while (sent < target) begin
         // when asked, the sender waits midway for every outstanding record before going on
         if (pause_midway && sent == target / 2) settle_block();
         send_byte(next_stream_byte(FEED_NORMAL));
         sent++;
      end
      // mostly stop on a packet edge; otherwise the next settings land mid-packet
      if ($urandom_range(3) != 0)
         while (!at_packet_edge()) send_byte(next_stream_byte(FEED_NORMAL));
   endtask

   initial begin
      logic [15:0]   w, h;
      logic [2:0]    bpp;
      logic [3:0]    alpha;
      int            pick, wide, guard;
      ending_type    ending;
      feed_mode_type feed;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full-width single row (height of zero acts as one), mirrored columns
      configure(16'd65535, 16'd0, 3'd4, 4'd8, 1'b1, 1'b0, 1'b1, 1'b0);
      // repeat of one, repeat of 128, raw packet of two
      send_bytes('{8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h01, 8'h01, 8'h02, 8'h03, 8'h04, 8'h80, 8'h00, 8'h00, 8'h7F});
      settle_block();
      // plain gray pixels; out-of-range pixel size ignored in gray mode
      configure(16'd65535, 16'd0, 3'd7, 4'd3, 1'b0, 1'b1, 1'b0, 1'b1);
      send_bytes('{8'h00, 8'hFF});
      settle_block();
      // two-byte pixel with one alpha bit rotated down
      configure(16'd65535, 16'd0, 3'd2, 4'd1, 1'b0, 1'b0, 1'b0, 1'b1);
      send_bytes('{8'h01, 8'h80});
      settle_block();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         pick = $urandom_range(5);
         case (pick)
            0: w = 16'd0;
            1: w = 16'd1;
            2: w = 16'd65535;
            3: w = 16'($urandom_range(2, 16));
            default: w = 16'($urandom_range(2, 65535));
         endcase
         h = ($urandom_range(1) != 0) ? 16'd65535 : 16'($urandom_range(40000, 65535));
         // keep plenty of pixels ahead so no run can finish the image here
         if (board.pixels_left_with(w, h) < 50000) begin
            w = 16'd65535;
            h = 16'd65535;
         end
         bpp = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
         pick = $urandom_range(5);
         alpha = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd1 : (pick == 2) ? 4'd8 :
                 4'($urandom_range(15));
         configure(w, h, bpp, alpha, $urandom_range(9) < 7, $urandom_range(3) == 0,
                   1'($urandom_range(1)), 1'($urandom_range(1)));
         steady = (p == 4);
         run_phase(PHASE_BYTES, p == 7);
         steady = 1'b0;
         settle_block();
      end

      // closing phase: finish the image exactly, overrun it, or fall outside it
      ending = ending_type'($urandom_range(2));
      if (ending == END_OUTSIDE && board.row == 16'd0 && board.column == 16'd0)
         ending = END_OVERRUN;
      case (ending)
         END_OUTSIDE: begin
            if (board.row != 16'd0) begin
               w = board.image_width;
               h = board.row;
            end else begin
               w = board.column;
               h = 16'd1;
            end
            feed = FEED_FINISH;
         end
         default: begin
            // last row only, a few pixels past the current column
            wide = int'(board.column) + 1 + $urandom_range(ending == END_OVERRUN ? 100 : 200);
            w = (wide > 65535) ? 16'd65535 : 16'(wide);
            h = board.row + 16'd1;
            feed = (ending == END_OVERRUN) ? FEED_OVERRUN : FEED_FINISH;
         end
      endcase
      bpp = 3'($urandom_range(7));
      alpha = 4'($urandom_range(15));
      configure(w, h, bpp, alpha, (ending == END_OVERRUN) || $urandom_range(1) != 0,
                $urandom_range(3) == 0, 1'($urandom_range(1)), 1'($urandom_range(1)));
      guard = 0;
      while (!board.halted && guard < 5000) begin
         send_byte(next_stream_byte(feed));
         guard++;
      end
      // decoder has stopped: these must leave no record
      repeat (10) send_byte(8'($urandom_range(255)));
      settle_block();

      if (board.failures == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
